### hdl/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types and constants for the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

   localparam int SIZE_BITS = 17;
   localparam int ID_BITS   = 16;
   localparam int CFG_BITS  = 17;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOFIT   = 2'd1,
      STATUS_UNKNOWN = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_NEXT,
      OP_FSCAN_HIT,
      OP_SLOT_HIT,
      OP_REMOVE_STEP,
      OP_REMOVE_END,
      OP_INS_FRONT,
      OP_INS_SCAN,
      OP_INS_FOUND,
      OP_SHIFT_STEP,
      OP_INS_WRITE,
      OP_COMMIT,
      OP_ID_HIT,
      OP_FREE_GO,
      OP_ERROR,
      OP_RESPOND
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic fscan_hit;
      logic fscan_end;
      logic slot_empty;
      logic id_hit;
      logic used_last;
      logic remove_done;
      logic has_rem;
      logic ins_front;
      logic ins_found;
      logic at_pos;
      logic free_full;
      logic out_free;
   } sts_type;

endpackage

### hdl/bfba_ctrl.sv
// ----------------------------------------------------------------------------
// bfba_ctrl
// Request sequencer: walks the table scans, shifts and result hand-off.
// ----------------------------------------------------------------------------
module bfba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_type,
   output logic              req_stall,
   input  bfba_pkg::sts_type sts,
   output bfba_pkg::cmd_type cmd
);
   import bfba_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b00000000001,
      ST_FSCAN     = 11'b00000000010,
      ST_USLOT     = 11'b00000000100,
      ST_REMOVE    = 11'b00000001000,
      ST_INS_START = 11'b00000010000,
      ST_INS_SCAN  = 11'b00000100000,
      ST_SHIFT     = 11'b00001000000,
      ST_COMMIT    = 11'b00010000000,
      ST_UFIND     = 11'b00100000000,
      ST_FREE_CHK  = 11'b01000000000,
      ST_RESULT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.status = STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = (req_type == REQ_FREE) ? ST_UFIND : ST_FSCAN;
            end
         end
         ST_FSCAN: begin
            priority if (sts.fscan_end) begin
               cmd.op     = OP_ERROR;
               cmd.status = STATUS_NOFIT;
               state_in   = ST_RESULT;
            end else if (sts.fscan_hit) begin
               cmd.op   = OP_FSCAN_HIT;
               state_in = ST_USLOT;
            end else begin
               cmd.op = OP_NEXT;
            end
         end
         ST_USLOT: begin
            priority if (sts.slot_empty) begin
               cmd.op   = OP_SLOT_HIT;
               state_in = ST_REMOVE;
            end else if (sts.used_last) begin
               cmd.op     = OP_ERROR;
               cmd.status = STATUS_FULL;
               state_in   = ST_RESULT;
            end else begin
               cmd.op = OP_NEXT;
            end
         end
         ST_REMOVE: begin
            if (sts.remove_done) begin
               cmd.op   = OP_REMOVE_END;
               state_in = sts.has_rem ? ST_INS_START : ST_COMMIT;
            end else begin
               cmd.op = OP_REMOVE_STEP;
            end
         end
         ST_INS_START: begin
            if (sts.ins_front) begin
               cmd.op   = OP_INS_FRONT;
               state_in = ST_SHIFT;
            end else begin
               cmd.op   = OP_INS_SCAN;
               state_in = ST_INS_SCAN;
            end
         end
         ST_INS_SCAN: begin
            if (sts.ins_found) begin
               cmd.op   = OP_INS_FOUND;
               state_in = ST_SHIFT;
            end else begin
               cmd.op = OP_NEXT;
            end
         end
         ST_SHIFT: begin
            if (sts.at_pos) begin
               cmd.op   = OP_INS_WRITE;
               state_in = sts.is_free ? ST_RESULT : ST_COMMIT;
            end else begin
               cmd.op = OP_SHIFT_STEP;
            end
         end
         ST_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = ST_RESULT;
         end
         ST_UFIND: begin
            priority if (sts.id_hit) begin
               cmd.op   = OP_ID_HIT;
               state_in = ST_FREE_CHK;
            end else if (sts.used_last) begin
               cmd.op     = OP_ERROR;
               cmd.status = STATUS_UNKNOWN;
               state_in   = ST_RESULT;
            end else begin
               cmd.op = OP_NEXT;
            end
         end
         ST_FREE_CHK: begin
            if (sts.free_full) begin
               cmd.op     = OP_ERROR;
               cmd.status = STATUS_FULL;
               state_in   = ST_RESULT;
            end else begin
               cmd.op   = OP_FREE_GO;
               state_in = ST_INS_START;
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.op   = OP_RESPOND;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/bfba_datapath.sv
// ----------------------------------------------------------------------------
// bfba_datapath
// Free and used tables, scan index, working registers and response register.
// ----------------------------------------------------------------------------
module bfba_datapath #(
   parameter int FREE_ENTRIES = 16,
   parameter int USED_ENTRIES = 16,
   parameter int ADDR_BITS    = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [bfba_pkg::CFG_BITS-1:0]  csr_wdata,
   input  logic                       req_type,
   input  logic [bfba_pkg::SIZE_BITS-1:0] req_alloc_size,
   input  logic [bfba_pkg::ID_BITS-1:0]   req_free_id,
   input  bfba_pkg::cmd_type          cmd,
   output bfba_pkg::sts_type          sts,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [bfba_pkg::ID_BITS-1:0]   rsp_granted_id,
   output logic [ADDR_BITS-1:0]       rsp_block_start,
   output logic [ADDR_BITS-1:0]       rsp_block_end
);
   import bfba_pkg::*;

   localparam int LEN_BITS = ADDR_BITS + 1;
   localparam int CMP_BITS = (LEN_BITS > SIZE_BITS) ? LEN_BITS : SIZE_BITS;
   localparam int FI_BITS  = $clog2(FREE_ENTRIES);
   localparam int UI_BITS  = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
   localparam int MAX_E    = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
   localparam int IDX_BITS = $clog2(MAX_E + 1);
   localparam int CNT_BITS = $clog2(FREE_ENTRIES + 1);

   logic [ADDR_BITS-1:0] fbase_ff [FREE_ENTRIES];
   logic [LEN_BITS-1:0]  flen_ff  [FREE_ENTRIES];
   logic [CNT_BITS-1:0]  count_ff;

   logic [USED_ENTRIES-1:0] used_valid_ff;
   logic [ID_BITS-1:0]      used_id_ff    [USED_ENTRIES];
   logic [ADDR_BITS-1:0]    used_first_ff [USED_ENTRIES];
   logic [ADDR_BITS-1:0]    used_last_ff  [USED_ENTRIES];
   logic [ID_BITS-1:0]      next_id_ff;

   logic [IDX_BITS-1:0]  idx_ff, fpos_ff, pos_ff;
   logic [UI_BITS-1:0]   uslot_ff;
   logic                 type_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [ADDR_BITS-1:0] sel_base_ff, ins_base_ff;
   logic [LEN_BITS-1:0]  sel_len_ff, ins_len_ff;

   status_type           res_status_ff;
   logic [ID_BITS-1:0]   res_gid_ff;
   logic [ADDR_BITS-1:0] res_first_ff, res_last_ff;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [ID_BITS-1:0]   rsp_gid_ff;
   logic [ADDR_BITS-1:0] rsp_first_ff, rsp_last_ff;

   logic [FI_BITS-1:0]   fi, fip1, fim1, pos_fi;
   logic [UI_BITS-1:0]   ui;
   logic [IDX_BITS-1:0]  cnt_ext;
   logic [CMP_BITS-1:0]  size_cmp, cur_len_cmp, ins_len_cmp, head_len_cmp;
   logic [CMP_BITS:0]    sum_ext;
   logic [CMP_BITS-1:0]  cfg_ext, mem_max, cfg_sat;
   logic [LEN_BITS-1:0]  free_len;

   assign fi       = idx_ff[FI_BITS-1:0];
   assign fip1     = FI_BITS'(idx_ff + IDX_BITS'(1));
   assign fim1     = FI_BITS'(idx_ff - IDX_BITS'(1));
   assign pos_fi   = pos_ff[FI_BITS-1:0];
   assign ui       = idx_ff[UI_BITS-1:0];
   assign cnt_ext  = IDX_BITS'(count_ff);

   assign size_cmp     = CMP_BITS'(size_ff);
   assign cur_len_cmp  = CMP_BITS'(flen_ff[fi]);
   assign ins_len_cmp  = CMP_BITS'(ins_len_ff);
   assign head_len_cmp = CMP_BITS'(flen_ff[0]);
   assign sum_ext      = (CMP_BITS+1)'(sel_base_ff) + (CMP_BITS+1)'(size_ff);
   assign free_len     = LEN_BITS'(res_last_ff) - LEN_BITS'(res_first_ff) + LEN_BITS'(1);

   assign cfg_ext = CMP_BITS'(csr_wdata);
   assign mem_max = CMP_BITS'(1) << ADDR_BITS;
   assign cfg_sat = (cfg_ext > mem_max) ? mem_max : cfg_ext;

   always_comb begin
      sts.is_free     = type_ff;
      sts.fscan_hit   = (idx_ff < cnt_ext) && (size_ff != '0) && (cur_len_cmp >= size_cmp);
      sts.fscan_end   = (idx_ff >= cnt_ext) || (size_ff == '0);
      sts.slot_empty  = !used_valid_ff[ui];
      sts.id_hit      = used_valid_ff[ui] && (used_id_ff[ui] == id_ff);
      sts.used_last   = (idx_ff == IDX_BITS'(USED_ENTRIES - 1));
      sts.remove_done = ((IDX_BITS+1)'(idx_ff) + (IDX_BITS+1)'(1)) >= (IDX_BITS+1)'(count_ff);
      sts.has_rem     = (CMP_BITS'(sel_len_ff) != size_cmp);
      sts.ins_front   = (count_ff == '0) || (ins_len_cmp < head_len_cmp);
      sts.ins_found   = (idx_ff >= cnt_ext) || (cur_len_cmp >= ins_len_cmp);
      sts.at_pos      = (idx_ff == pos_ff);
      sts.free_full   = (count_ff >= CNT_BITS'(FREE_ENTRIES));
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= CNT_BITS'(1);
         fbase_ff[0]   <= '0;
         flen_ff[0]    <= LEN_BITS'(mem_max);
         used_valid_ff <= '0;
         next_id_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.op == OP_RESPOND) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            count_ff      <= (cfg_sat == '0) ? CNT_BITS'(0) : CNT_BITS'(1);
            fbase_ff[0]   <= '0;
            flen_ff[0]    <= LEN_BITS'(cfg_sat);
            used_valid_ff <= '0;
         end else begin
            unique case (cmd.op)
               OP_REMOVE_STEP: begin
                  fbase_ff[fi] <= fbase_ff[fip1];
                  flen_ff[fi]  <= flen_ff[fip1];
               end
               OP_REMOVE_END: begin
                  count_ff <= count_ff - CNT_BITS'(1);
               end
               OP_SHIFT_STEP: begin
                  fbase_ff[fi] <= fbase_ff[fim1];
                  flen_ff[fi]  <= flen_ff[fim1];
               end
               OP_INS_WRITE: begin
                  fbase_ff[pos_fi] <= ins_base_ff;
                  flen_ff[pos_fi]  <= ins_len_ff;
                  count_ff         <= count_ff + CNT_BITS'(1);
               end
               OP_COMMIT: begin
                  used_valid_ff[uslot_ff] <= 1'b1;
                  next_id_ff              <= next_id_ff + ID_BITS'(1);
               end
               OP_FREE_GO: begin
                  used_valid_ff[uslot_ff] <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            type_ff <= req_type;
            size_ff <= req_alloc_size;
            id_ff   <= req_free_id;
            idx_ff  <= '0;
         end
         OP_NEXT: begin
            idx_ff <= idx_ff + IDX_BITS'(1);
         end
         OP_FSCAN_HIT: begin
            fpos_ff     <= idx_ff;
            sel_base_ff <= fbase_ff[fi];
            sel_len_ff  <= flen_ff[fi];
            idx_ff      <= '0;
         end
         OP_SLOT_HIT: begin
            uslot_ff <= ui;
            idx_ff   <= fpos_ff;
         end
         OP_REMOVE_STEP: begin
            idx_ff <= idx_ff + IDX_BITS'(1);
         end
         OP_REMOVE_END: begin
            ins_base_ff <= ADDR_BITS'(sum_ext);
            ins_len_ff  <= LEN_BITS'(CMP_BITS'(sel_len_ff) - size_cmp);
         end
         OP_INS_FRONT: begin
            pos_ff <= '0;
            idx_ff <= cnt_ext;
         end
         OP_INS_SCAN: begin
            idx_ff <= IDX_BITS'(1);
         end
         OP_INS_FOUND: begin
            pos_ff <= idx_ff;
            idx_ff <= cnt_ext;
         end
         OP_SHIFT_STEP: begin
            idx_ff <= idx_ff - IDX_BITS'(1);
         end
         OP_COMMIT: begin
            used_id_ff[uslot_ff]    <= next_id_ff;
            used_first_ff[uslot_ff] <= sel_base_ff;
            used_last_ff[uslot_ff]  <= ADDR_BITS'(sum_ext - (CMP_BITS+1)'(1));
            res_status_ff           <= STATUS_OK;
            res_gid_ff              <= next_id_ff;
            res_first_ff            <= sel_base_ff;
            res_last_ff             <= ADDR_BITS'(sum_ext - (CMP_BITS+1)'(1));
         end
         OP_ID_HIT: begin
            uslot_ff      <= ui;
            res_status_ff <= STATUS_OK;
            res_gid_ff    <= id_ff;
            res_first_ff  <= used_first_ff[ui];
            res_last_ff   <= used_last_ff[ui];
         end
         OP_FREE_GO: begin
            ins_base_ff <= res_first_ff;
            ins_len_ff  <= free_len;
         end
         OP_ERROR: begin
            res_status_ff <= cmd.status;
            res_gid_ff    <= '0;
            res_first_ff  <= '0;
            res_last_ff   <= '0;
         end
         OP_RESPOND: begin
            rsp_status_ff <= res_status_ff;
            rsp_gid_ff    <= res_gid_ff;
            rsp_first_ff  <= res_first_ff;
            rsp_last_ff   <= res_last_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_granted_id  = rsp_gid_ff;
   assign rsp_block_start = rsp_first_ff;
   assign rsp_block_end   = rsp_last_ff;

endmodule

### hdl/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a linear memory, free table kept in size order.
// ----------------------------------------------------------------------------
// One request at a time. An allocate loads the request, scans the free
// table for a fit, scans the used table for an empty slot, removes the
// chosen free entry, inserts any remainder with a scan and shifts, then
// commits and responds; a free scans the used table for the id, checks the
// free table for room, inserts the freed block and responds. The table
// walks step one entry per cycle. A finished response waits in an output
// register while the next request is accepted. A csr write sets the memory
// size and resets both tables at once.
module best_fit_block_allocator #(
   parameter int FREE_ENTRIES = 16,
   parameter int USED_ENTRIES = 16,
   parameter int ADDR_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [16:0]           csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [16:0]           req_alloc_size,
   input  logic [15:0]           req_free_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [15:0]           rsp_granted_id,
   output logic [ADDR_BITS-1:0]  rsp_block_start,
   output logic [ADDR_BITS-1:0]  rsp_block_end
);
   import bfba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfba_datapath #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .USED_ENTRIES (USED_ENTRIES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_type        (req_type),
      .req_alloc_size  (req_alloc_size),
      .req_free_id     (req_free_id),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_granted_id  (rsp_granted_id),
      .rsp_block_start (rsp_block_start),
      .rsp_block_end   (rsp_block_end)
   );

`ifndef ASSERT_OFF
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (cmd.op == OP_LOAD))
      else $error("accepted request not loaded");

   a_respond_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESPOND) |-> sts.out_free)
      else $error("response overwrites pending output");

   a_respond_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESPOND) |=> rsp_valid)
      else $error("response not presented");
`endif

endmodule
